// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the sorted priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SRPQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SRPQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRPQ_ASSERT(name, prop, msg)
`define SRPQ_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ===== rtl/srpq_pkg.sv =====
// Types and codes of the sorted priority queue.
package srpq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic               op;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         occupancy;
  } result_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

// ===== rtl/sorted_ring_priority_queue.sv =====
// Top level of the sorted priority queue: a chain of compare-and-shift cells.
// Values are held sorted, largest first, one per cell; equal values leave in arrival order.
// An item (insert or remove) is taken on any cycle where start is high; busy never rises, so
// one item a cycle is sustained. Every cell compares the new value with its own in that single
// cycle and shifts one place, so its result appears with done exactly one cycle after start,
// for that one cycle only: the receiver cannot stall and must take it then. A full queue
// refuses an insert and an empty one refuses a remove, leaving the contents unchanged.
`include "assert_macros.svh"
module sorted_ring_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  srpq_pkg::item_t   item,
  output logic              done,
  output srpq_pkg::result_t result
);
  import srpq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [CW+4:0]      count_ext;
  logic               accept;
  logic               is_full;
  logic               is_empty;
  cell_ctl_t          ctl;
  logic signed [31:0] data      [DEPTH];
  logic signed [31:0] prev_data [DEPTH];
  logic signed [31:0] next_data [DEPTH];
  logic               ins_here  [DEPTH];
  logic               prev_ins  [DEPTH];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);

  always_comb begin
    ctl.value  = item.value;
    ctl.cmd    = CMD_HOLD;
    count_next = count;
    if (accept) begin
      if (item.op == OP_REMOVE) begin
        if (!is_empty) begin
          ctl.cmd    = CMD_REMOVE;
          count_next = count - CW'(1);
        end
      end else if (!is_full) begin
        ctl.cmd    = CMD_INSERT;
        count_next = count + CW'(1);
      end
    end
  end

  assign count_ext = {5'd0, count_next};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_data[i] = '0;
      assign prev_ins[i]  = 1'b0;
    end else begin : g_body
      assign prev_data[i] = data[i-1];
      assign prev_ins[i]  = ins_here[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_data[i] = '0;
    end else begin : g_link
      assign next_data[i] = data[i+1];
    end

    srpq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (count > CW'(i)),
      .prev_data (prev_data[i]),
      .prev_ins  (prev_ins[i]),
      .next_data (next_data[i]),
      .data      (data[i]),
      .ins_here  (ins_here[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
    if (accept) begin
      result.occupancy <= count_ext[4:0];
      if (item.op == OP_REMOVE) begin
        if (is_empty) begin
          result.status        <= STATUS_EMPTY;
          result.removed_value <= '0;
        end else begin
          result.status        <= STATUS_DONE;
          result.removed_value <= data[0];
        end
      end else begin
        result.removed_value <= '0;
        if (is_full) begin
          result.status <= STATUS_FULL;
        end else begin
          result.status <= STATUS_DONE;
        end
      end
    end
  end

  `SRPQ_ASSERT_ALWAYS(a_count_bound, rst || count <= CW'(DEPTH), "occupancy above depth")
  `SRPQ_ASSERT(a_done_follows, accept |=> done, "accepted word gave no result")
  `SRPQ_ASSERT(a_no_spurious, !accept |=> !done && $stable(count), "result without word")
  `SRPQ_ASSERT(a_full_refused,
    accept && item.op == OP_INSERT && is_full |=> result.status == STATUS_FULL && $stable(count),
    "full insert not refused")
  `SRPQ_ASSERT(a_empty_refused,
    accept && item.op == OP_REMOVE && is_empty |=>
      result.status == STATUS_EMPTY && result.removed_value == 0,
    "empty remove not refused")

endmodule

// ===== rtl/srpq_cell.sv =====
// One slot of the sorted chain: holds a value, shifts toward tail on insert, toward head on remove.
module srpq_cell (
  input  logic                      clk,
  input  srpq_pkg::cell_ctl_t       ctl,
  input  logic                      occupied,
  input  logic signed [31:0]        prev_data,
  input  logic                      prev_ins,
  input  logic signed [31:0]        next_data,
  output logic signed [31:0]        data,
  output logic                      ins_here
);
  import srpq_pkg::*;

  assign ins_here = !occupied || (ctl.value > data);

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      CMD_INSERT: begin
        if (ins_here) begin
          data <= prev_ins ? prev_data : ctl.value;
        end
      end
      CMD_REMOVE: begin
        data <= next_data;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== bench/sorted_ring_priority_queue_tb.sv =====
// Self-checking testbench for the sorted priority queue: directed and random insert/remove words.
module sorted_ring_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srpq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int STALL_LIMIT = 2000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  logic    clk;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   word_in = '0;
  logic    done;
  result_t word_out;

  logic signed [31:0] held_values[$];
  result_t            pending_results[$];
  int                 fail_count = 0;
  int                 idle_cycles = 0;
  int                 insert_count = 0;
  int                 remove_count = 0;
  int                 full_refusals = 0;
  int                 empty_refusals = 0;
  int                 peak_fill = 0;

  sorted_ring_priority_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(word_in),
    .done(done),
    .result(word_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic result_t apply_word(item_t w);
    result_t r;
    int      pos;
    r = '0;
    r.status = STATUS_DONE;
    if (w.op == OP_INSERT) begin
      insert_count++;
      if (held_values.size() >= QUEUE_DEPTH) begin
        r.status = STATUS_FULL;
        full_refusals++;
      end else begin
        pos = held_values.size();
        for (int i = 0; i < held_values.size(); i++) begin
          if (held_values[i] < w.value) begin
            pos = i;
            break;
          end
        end
        held_values.insert(pos, w.value);
      end
    end else begin
      remove_count++;
      if (held_values.size() == 0) begin
        r.status = STATUS_EMPTY;
        empty_refusals++;
      end else begin
        r.removed_value = held_values.pop_front();
      end
    end
    if (held_values.size() > peak_fill) peak_fill = held_values.size();
    r.occupancy = 5'(held_values.size());
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (word_out.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, word_out.status);
          fail_count++;
        end
        if (word_out.removed_value !== want.removed_value) begin
          $error("removed_value: expected %0d, actual %0d",
                 want.removed_value, word_out.removed_value);
          fail_count++;
        end
        if (word_out.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", want.occupancy, word_out.occupancy);
          fail_count++;
        end
      end
    end
    if (!rst && start && !busy) pending_results.push_back(apply_word(word_in));
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic op, input logic signed [31:0] value, input int idle_pct);
    item_t w;
    w.op = op;
    w.value = value;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
    word_in <= w;
    start <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $signed($urandom_range(0, 8)) - 4;
      4:          v = VAL_MAX;
      5:          v = VAL_MIN;
      default:    v = $urandom;
    endcase
    return v;
  endfunction

  task automatic test_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_empty_and_last();
    send_word(OP_REMOVE, $urandom, 0);
    send_word(OP_INSERT, 32'sd7, 0);
    send_word(OP_REMOVE, 32'sd0, 0);
  endtask

  task automatic test_fill_extremes();
    logic signed [31:0] fill[16];
    fill = '{VAL_MAX, VAL_MIN, 32'sd0, -32'sd1, 32'sd1, 32'sd5, 32'sd5, 32'sd5,
             VAL_MAX, VAL_MIN, 32'sh5555_5555, 32'shaaaa_aaaa, -32'sd1, 32'sd2,
             32'sh0000_ffff, 32'shffff_0000};
    foreach (fill[i]) send_word(OP_INSERT, fill[i], 0);
    send_word(OP_INSERT, 32'sd9, 0);
    repeat (3) send_word(OP_REMOVE, $urandom, 0);
    drain_results();
  endtask

  task automatic test_random(input int count, input int idle_pct);
    int sent;
    int ins_pct;
    int run_len;
    bit paused;
    sent = 0;
    paused = 1'b0;
    while (sent < count) begin
      case ($urandom_range(0, 2))
        0:       ins_pct = 85;
        1:       ins_pct = 15;
        default: ins_pct = 50;
      endcase
      run_len = $urandom_range(1, 24);
      for (int k = 0; k < run_len && sent < count; k++) begin
        if ($urandom_range(0, 99) < ins_pct) begin
          send_word(OP_INSERT, pick_value(), idle_pct);
        end else begin
          send_word(OP_REMOVE, $urandom, idle_pct);
        end
        sent++;
      end
      if (!paused && sent >= count / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    test_reset();
    test_empty_and_last();
    test_fill_extremes();
    test_random(200, 7);
    test_random(200, 56);
    test_random(200, 0);
    drain_results();
    repeat (4) @(posedge clk);
    $display("Covered %0d inserts (%0d refused full) and %0d removes (%0d refused empty),",
             insert_count, full_refusals, remove_count, empty_refusals);
    $display("with occupancy reaching %0d and sender gaps at 7%%, 56%% and none.", peak_fill);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
